@@ sv/gps_fix_median_motion_tracker_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the position filter and motion tracker.
// Each macro expands to one labeled concurrent assertion clocked on the
// rising edge and disabled while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef GPS_FIX_MEDIAN_MOTION_TRACKER_ASSERT_SVH
`define GPS_FIX_MEDIAN_MOTION_TRACKER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GFMT_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gfmt: same-cycle property failed");

// The consequent must hold in the cycle after the antecedent.
`define GFMT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gfmt: next-cycle property failed");

`endif

@@ sv/gfmt_pkg.sv @@
// ----------------------------------------------------------------------------
// gfmt_pkg
// Shared widths, reset values, register indexes, the queue entry type, the
// back-end state type and the median helper for the motion tracker.
// ----------------------------------------------------------------------------
package gfmt_pkg;

  // Field widths.
  localparam int unsigned LatW     = 31;
  localparam int unsigned LonW     = 32;
  localparam int unsigned HdopW    = 14;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned DistW    = 32;
  localparam int unsigned ThrW     = 16;
  localparam int unsigned CfgDataW = 16;

  // Reset values.
  localparam logic [HdopW-1:0] HdopLimitRst = 14'd300;
  localparam logic [ThrW-1:0]  MoveThrRst   = 16'd1000;
  localparam logic [HdopW-1:0] HeldHdopRst  = 14'd9990;

  // Ring of recent locations.
  localparam int unsigned WinDepth = 3;
  localparam int unsigned SlotW    = 2;

  // Default depth of the queue between front and back.
  localparam int unsigned QueueDepthDef = 2;

  // Distance scaling: one 1e-7 degree step is 11132/1000 mm.
  localparam logic [13:0] DistScale = 14'd11132;
  localparam logic [10:0] DistDen   = 11'd1000;

  // Square root: one result bit per cycle.
  localparam int unsigned SqrtSteps = 32;
  localparam int unsigned SqrtCntW  = 5;

  // Divide by 1000: four quotient bits per cycle over a 48 bit dividend.
  localparam int unsigned DivBits     = 48;
  localparam int unsigned DivStepBits = 4;
  localparam int unsigned DivSteps    = DivBits / DivStepBits;
  localparam int unsigned DivCntW     = 4;

  // Configuration register indexes.
  typedef enum logic {
    CfgHdopLimit = 1'b0,
    CfgMoveThr   = 1'b1
  } cfg_index_e;

  // One classified report travelling from front to back.
  typedef struct packed {
    logic signed [LatW-1:0] lat;
    logic signed [LonW-1:0] lon;
    logic                   fix;
    logic                   acquired;
    logic                   lost;
    logic [TimeW-1:0]       now;
  } job_t;

  // Back-end sequencer states.
  typedef enum logic [3:0] {
    BkIdle,
    BkDiff,
    BkSqA,
    BkSqB,
    BkSum,
    BkStart,
    BkSqrt,
    BkScale,
    BkDiv,
    BkEval,
    BkWrite
  } back_state_e;

  // Median of three signed values; equal values give that value.
  function automatic logic signed [31:0] med3(input logic signed [31:0] a,
                                              input logic signed [31:0] b,
                                              input logic signed [31:0] c);
    logic signed [31:0] lo;
    logic signed [31:0] hi;
    logic signed [31:0] m;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    m  = (hi < c) ? hi : c;
    return (lo > m) ? lo : m;
  endfunction

endpackage

@@ sv/gfmt_front.sv @@
// ----------------------------------------------------------------------------
// gfmt_front
// Accepts reports, keeps the location ring and the held HDOP, decides the
// fix and its edges, picks median or raw position and queues the job.
// ----------------------------------------------------------------------------
module gfmt_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic signed [gfmt_pkg::LatW-1:0] report_lat_i,
  input  logic signed [gfmt_pkg::LonW-1:0] report_lon_i,
  input  logic                           location_updated_i,
  input  logic                           location_valid_i,
  input  logic                           hdop_valid_i,
  input  logic [gfmt_pkg::HdopW-1:0]     hdop_value_i,
  input  logic [gfmt_pkg::TimeW-1:0]     now_ms_i,
  input  logic [gfmt_pkg::HdopW-1:0]     hdop_limit_i,
  input  logic                           queue_full_i,
  output logic                           push_o,
  output gfmt_pkg::job_t                 job_o
);
  import gfmt_pkg::*;

  logic signed [LatW-1:0] lat_win_q [WinDepth];
  logic signed [LatW-1:0] lat_win_d [WinDepth];
  logic signed [LonW-1:0] lon_win_q [WinDepth];
  logic signed [LonW-1:0] lon_win_d [WinDepth];
  logic [SlotW-1:0]       slot_q, slot_d;
  logic                   full_q, full_d;
  logic [HdopW-1:0]       hdop_q, hdop_d;
  logic                   prev_fix_q;
  logic                   accept;
  logic                   write_loc;
  logic                   fix;
  logic                   use_med;
  logic signed [31:0]     med_lat;
  logic signed [31:0]     med_lon;

  // A beat is taken whenever the queue has room.
  assign in_ready_o = !queue_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign write_loc  = location_updated_i && location_valid_i;

  // Ring update: a new valid location overwrites the oldest slot.
  always_comb begin
    lat_win_d = lat_win_q;
    lon_win_d = lon_win_q;
    slot_d    = slot_q;
    full_d    = full_q;
    if (write_loc) begin
      lat_win_d[slot_q] = report_lat_i;
      lon_win_d[slot_q] = report_lon_i;
      if (slot_q == SlotW'(WinDepth - 1)) begin
        slot_d = '0;
        full_d = 1'b1;
      end else begin
        slot_d = slot_q + 1'b1;
      end
    end
  end

  // Held HDOP and fix decision use the value after this report.
  assign hdop_d = hdop_valid_i ? hdop_value_i : hdop_q;
  assign fix    = location_valid_i && (hdop_d < hdop_limit_i);

  // Median per axis over the updated ring.
  assign med_lat = med3({lat_win_d[0][LatW-1], lat_win_d[0]},
                        {lat_win_d[1][LatW-1], lat_win_d[1]},
                        {lat_win_d[2][LatW-1], lat_win_d[2]});
  assign med_lon = med3(lon_win_d[0], lon_win_d[1], lon_win_d[2]);
  assign use_med = full_d && location_valid_i;

  // Job handed to the back end.
  always_comb begin
    job_o.lat      = use_med ? med_lat[LatW-1:0] : report_lat_i;
    job_o.lon      = use_med ? med_lon : report_lon_i;
    job_o.fix      = fix;
    job_o.acquired = fix && !prev_fix_q;
    job_o.lost     = !fix && prev_fix_q;
    job_o.now      = now_ms_i;
  end
  assign push_o = accept;

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q     <= '0;
      full_q     <= 1'b0;
      hdop_q     <= HeldHdopRst;
      prev_fix_q <= 1'b0;
    end else if (accept) begin
      slot_q     <= slot_d;
      full_q     <= full_d;
      hdop_q     <= hdop_d;
      prev_fix_q <= fix;
    end
  end

  // Ring contents; only read once every slot has been written.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      lat_win_q <= lat_win_d;
      lon_win_q <= lon_win_d;
    end
  end

endmodule

@@ sv/gfmt_queue.sv @@
// ----------------------------------------------------------------------------
// gfmt_queue
// Short first-in first-out queue of classified jobs between front and back.
// ----------------------------------------------------------------------------
module gfmt_queue #(
  parameter int unsigned Depth = gfmt_pkg::QueueDepthDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  gfmt_pkg::job_t push_data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output gfmt_pkg::job_t pop_data_o
);
  import gfmt_pkg::*;

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign full_o     = (count_q == CntW'(Depth));
  assign valid_o    = (count_q != '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

@@ sv/gfmt_isqrt.sv @@
// ----------------------------------------------------------------------------
// gfmt_isqrt
// Integer square root of a 64 bit value, one result bit per cycle.
// ----------------------------------------------------------------------------
module gfmt_isqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] radicand_i,
  output logic        done_o,
  output logic [31:0] root_o
);
  import gfmt_pkg::*;

  logic                run_q;
  logic                done_q;
  logic [SqrtCntW-1:0] cnt_q;
  logic [63:0]         rad_q;
  logic [32:0]         rem_q;
  logic [31:0]         root_q;
  logic [34:0]         rem_sh;
  logic [34:0]         trial;
  logic                ge;
  logic [32:0]         rem_nx;

  // One digit step: bring down two bits and try the next root bit.
  assign rem_sh = {rem_q, rad_q[63:62]};
  assign trial  = {1'b0, root_q, 2'b01};
  assign ge     = (rem_sh >= trial);
  assign rem_nx = ge ? 33'(rem_sh - trial) : rem_sh[32:0];

  assign done_o = done_q;
  assign root_o = root_q;

  // Step control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == SqrtCntW'(SqrtSteps - 1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= radicand_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (run_q) begin
      rad_q  <= {rad_q[61:0], 2'b00};
      rem_q  <= rem_nx;
      root_q <= {root_q[30:0], ge};
    end
  end

endmodule

@@ sv/gfmt_back.sv @@
// ----------------------------------------------------------------------------
// gfmt_back
// Takes queued jobs, measures the distance to the reference position,
// moves the reference and holds the finished result for the output side.
// ----------------------------------------------------------------------------
module gfmt_back (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             job_valid_i,
  input  gfmt_pkg::job_t                   job_i,
  output logic                             pop_o,
  input  logic [gfmt_pkg::ThrW-1:0]        move_thr_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic signed [gfmt_pkg::LatW-1:0] out_lat_o,
  output logic signed [gfmt_pkg::LonW-1:0] out_lon_o,
  output logic                             fix_valid_o,
  output logic                             fix_acquired_o,
  output logic                             fix_lost_o,
  output logic [gfmt_pkg::DistW-1:0]       distance_mm_o,
  output logic                             moved_o,
  output logic [gfmt_pkg::TimeW-1:0]       since_move_ms_o
);
  import gfmt_pkg::*;

  back_state_e            state_q, state_d;
  job_t                   job_q;
  logic signed [LatW-1:0] ref_lat_q;
  logic signed [LonW-1:0] ref_lon_q;
  logic [TimeW-1:0]       ref_time_q;
  logic [DistW-1:0]       held_dist_q;
  logic                   moved_q;
  logic                   ref_set;
  logic [31:0]            da_q, dn_q;
  logic [63:0]            sa_q, sb_q;
  logic [64:0]            sum_q;
  logic [DivBits-1:0]     div_q, div_nx;
  logic [9:0]             rem_q, rem_nx;
  logic [10:0]            rem_try;
  logic [DivCntW-1:0]     cnt_q;
  logic signed [31:0]     dlat;
  logic signed [32:0]     dlon;
  logic [DistW-1:0]       dist_sat;
  logic                   sqrt_start;
  logic                   sqrt_done;
  logic [31:0]            sqrt_root;
  logic                   load_out;
  logic [TimeW-1:0]       ref_time_nx;
  logic                   out_valid_q;

  // Stored zero in either axis means no reference yet.
  assign ref_set = (ref_lat_q != '0) && (ref_lon_q != '0);

  // Signed differences to the reference.
  assign dlat = {job_q.lat[LatW-1], job_q.lat} - {ref_lat_q[LatW-1], ref_lat_q};
  assign dlon = {job_q.lon[LonW-1], job_q.lon} - {ref_lon_q[LonW-1], ref_lon_q};

  // Four restoring steps of the divide by 1000 per cycle.
  always_comb begin
    div_nx  = div_q;
    rem_nx  = rem_q;
    rem_try = '0;
    for (int i = 0; i < DivStepBits; i++) begin
      rem_try = {rem_nx, div_nx[DivBits-1]};
      div_nx  = {div_nx[DivBits-2:0], rem_try >= DistDen};
      rem_nx  = (rem_try >= DistDen) ? 10'(rem_try - DistDen) : rem_try[9:0];
    end
  end

  // Quotient saturated to 32 bits.
  assign dist_sat = (div_q[DivBits-1:DistW] != '0) ? '1 : div_q[DistW-1:0];

  // Square root unit of the back end.
  gfmt_isqrt u_isqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sqrt_start),
    .radicand_i (sum_q[63:0]),
    .done_o     (sqrt_done),
    .root_o     (sqrt_root)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BkIdle: begin
        if (job_valid_i) begin
          state_d = (job_i.fix && ref_set) ? BkDiff : BkWrite;
        end
      end
      BkDiff:  state_d = BkSqA;
      BkSqA:   state_d = BkSqB;
      BkSqB:   state_d = BkSum;
      BkSum:   state_d = BkStart;
      BkStart: state_d = sum_q[64] ? BkWrite : BkSqrt;
      BkSqrt: begin
        if (sqrt_done) begin
          state_d = BkScale;
        end
      end
      BkScale: state_d = BkDiv;
      BkDiv: begin
        if (cnt_q == DivCntW'(DivSteps - 1)) begin
          state_d = BkEval;
        end
      end
      BkEval:  state_d = BkWrite;
      BkWrite: begin
        if (load_out) begin
          state_d = BkIdle;
        end
      end
      default: state_d = BkIdle;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    pop_o      = (state_q == BkIdle) && job_valid_i;
    sqrt_start = (state_q == BkStart) && !sum_q[64];
    load_out   = (state_q == BkWrite) && (!out_valid_q || out_ready_i);
  end

  // Reference time seen by the result of this job.
  assign ref_time_nx = moved_q ? job_q.now : ref_time_q;

  // Control state, reference and held distance.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BkIdle;
      ref_lat_q   <= '0;
      ref_lon_q   <= '0;
      ref_time_q  <= '0;
      held_dist_q <= '0;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == BkScale) begin
        cnt_q <= '0;
      end else if (state_q == BkDiv) begin
        cnt_q <= cnt_q + 1'b1;
      end
      if (state_q == BkStart && sum_q[64]) begin
        held_dist_q <= '1;
      end else if (state_q == BkEval) begin
        held_dist_q <= dist_sat;
      end
      if (load_out && moved_q) begin
        ref_lat_q  <= job_q.lat;
        ref_lon_q  <= job_q.lon;
        ref_time_q <= job_q.now;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      job_q   <= job_i;
      moved_q <= job_i.fix && !ref_set;
    end
    if (state_q == BkDiff) begin
      da_q <= dlat[31] ? 32'(-dlat) : 32'(dlat);
      dn_q <= dlon[32] ? 32'(-dlon) : 32'(dlon);
    end
    if (state_q == BkSqA) begin
      sa_q <= 64'(da_q) * 64'(da_q);
    end
    if (state_q == BkSqB) begin
      sb_q <= 64'(dn_q) * 64'(dn_q);
    end
    if (state_q == BkSum) begin
      sum_q <= {1'b0, sa_q} + {1'b0, sb_q};
    end
    if (state_q == BkStart && sum_q[64]) begin
      moved_q <= 1'b1;
    end
    if (state_q == BkScale) begin
      div_q <= DivBits'(sqrt_root) * DivBits'(DistScale);
      rem_q <= '0;
    end else if (state_q == BkDiv) begin
      div_q <= div_nx;
      rem_q <= rem_nx;
    end
    if (state_q == BkEval) begin
      moved_q <= dist_sat > DistW'(move_thr_i);
    end
  end

  // Output register; the back end may pick up the next job meanwhile.
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_lat_o       <= job_q.lat;
      out_lon_o       <= job_q.lon;
      fix_valid_o     <= job_q.fix;
      fix_acquired_o  <= job_q.acquired;
      fix_lost_o      <= job_q.lost;
      distance_mm_o   <= held_dist_q;
      moved_o         <= moved_q;
      since_move_ms_o <= (ref_time_nx == '0) ? '0 : job_q.now - ref_time_nx;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

@@ sv/gps_fix_median_motion_tracker.sv @@
// ----------------------------------------------------------------------------
// gps_fix_median_motion_tracker
// Median-of-three position filter with fix tracking and movement detection.
//
//   Channel   Direction  Handshake               Contents
//   in        input      in_valid_i/in_ready_o   one decoded receiver report
//   out       output     out_valid_o/out_ready_i one filtered result
//   cfg       input      cfg_we_i                hdop_limit, move_threshold_mm
//
// A report without fix, or the first fix, goes from the idle state of the back end
// straight to its write state. A report that measures distance also runs the 32 step
// square root and the divide by 1000; an overflowing square sum skips both.
// The front keeps accepting reports while the job queue has room.
// Reset clears the ring, the held HDOP (to 9990), the fix and the reference.
// A result held on a stalled output does not stop the back end from
// starting the next job.
// ----------------------------------------------------------------------------
module gps_fix_median_motion_tracker #(
  parameter int unsigned QueueDepth = gfmt_pkg::QueueDepthDef
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic signed [gfmt_pkg::LatW-1:0]   report_lat_i,
  input  logic signed [gfmt_pkg::LonW-1:0]   report_lon_i,
  input  logic                               location_updated_i,
  input  logic                               location_valid_i,
  input  logic                               hdop_valid_i,
  input  logic [gfmt_pkg::HdopW-1:0]         hdop_value_i,
  input  logic [gfmt_pkg::TimeW-1:0]         now_ms_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [gfmt_pkg::LatW-1:0]   out_lat_o,
  output logic signed [gfmt_pkg::LonW-1:0]   out_lon_o,
  output logic                               fix_valid_o,
  output logic                               fix_acquired_o,
  output logic                               fix_lost_o,
  output logic [gfmt_pkg::DistW-1:0]         distance_mm_o,
  output logic                               moved_o,
  output logic [gfmt_pkg::TimeW-1:0]         since_move_ms_o,
  input  logic                               cfg_we_i,
  input  gfmt_pkg::cfg_index_e               cfg_index_i,
  input  logic [gfmt_pkg::CfgDataW-1:0]      cfg_data_i
);
  import gfmt_pkg::*;

  logic [HdopW-1:0] hdop_limit_q;
  logic [ThrW-1:0]  move_thr_q;
  logic             push;
  job_t             push_job;
  logic             queue_full;
  logic             job_valid;
  job_t             pop_job;
  logic             pop;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdop_limit_q <= HdopLimitRst;
      move_thr_q   <= MoveThrRst;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgHdopLimit: hdop_limit_q <= cfg_data_i[HdopW-1:0];
        CfgMoveThr:   move_thr_q   <= cfg_data_i[ThrW-1:0];
        default:      ;
      endcase
    end
  end

  // Front: accept and classify.
  gfmt_front u_front (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .report_lat_i       (report_lat_i),
    .report_lon_i       (report_lon_i),
    .location_updated_i (location_updated_i),
    .location_valid_i   (location_valid_i),
    .hdop_valid_i       (hdop_valid_i),
    .hdop_value_i       (hdop_value_i),
    .now_ms_i           (now_ms_i),
    .hdop_limit_i       (hdop_limit_q),
    .queue_full_i       (queue_full),
    .push_o             (push),
    .job_o              (push_job)
  );

  // Job queue.
  gfmt_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_job),
    .full_o      (queue_full),
    .pop_i       (pop),
    .valid_o     (job_valid),
    .pop_data_o  (pop_job)
  );

  // Back: distance, reference and result.
  gfmt_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .job_valid_i     (job_valid),
    .job_i           (pop_job),
    .pop_o           (pop),
    .move_thr_i      (move_thr_q),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .out_lat_o       (out_lat_o),
    .out_lon_o       (out_lon_o),
    .fix_valid_o     (fix_valid_o),
    .fix_acquired_o  (fix_acquired_o),
    .fix_lost_o      (fix_lost_o),
    .distance_mm_o   (distance_mm_o),
    .moved_o         (moved_o),
    .since_move_ms_o (since_move_ms_o)
  );

endmodule

@@ sv/gfmt_checker.sv @@
// ----------------------------------------------------------------------------
// gfmt_checker
// Port-level checks on the result channel of the motion tracker.
// ----------------------------------------------------------------------------
`include "gps_fix_median_motion_tracker_assert.svh"

module gfmt_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [30:0] out_lat_o,
  input logic [31:0] distance_mm_o,
  input logic        fix_valid_o,
  input logic        fix_acquired_o,
  input logic        fix_lost_o,
  input logic        moved_o,
  input logic [31:0] since_move_ms_o
);

  // A stalled result beat stays put.
  `GFMT_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(out_lat_o) && $stable(distance_mm_o))

  // Fix edges agree with the fix flag of the same beat.
  `GFMT_ASSERT_SAME(a_acq_has_fix, clk_i, rst_ni, out_valid_o && fix_acquired_o, fix_valid_o)
  `GFMT_ASSERT_SAME(a_lost_no_fix, clk_i, rst_ni, out_valid_o && fix_lost_o, !fix_valid_o)

  // A moved reference was stamped with this beat's time.
  `GFMT_ASSERT_SAME(a_moved_since, clk_i, rst_ni, out_valid_o && moved_o, since_move_ms_o == 32'd0)

endmodule

bind gps_fix_median_motion_tracker gfmt_checker u_gfmt_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .out_lat_o       (out_lat_o),
  .distance_mm_o   (distance_mm_o),
  .fix_valid_o     (fix_valid_o),
  .fix_acquired_o  (fix_acquired_o),
  .fix_lost_o      (fix_lost_o),
  .moved_o         (moved_o),
  .since_move_ms_o (since_move_ms_o)
);

@@ sim/gps_fix_median_motion_tracker_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Result checker for the position filter and motion tracker
// Watches the report, result and register ports of the tracker, keeps its own
// model of the location ring, held HDOP, fix and reference position, and
// compares every accepted result beat field by field with the oldest
// prediction. Failures are counted and handed to the testbench top.
// ----------------------------------------------------------------------------
module gps_fix_median_motion_tracker_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  input  logic                             in_ready_i,
  input  logic signed [gfmt_pkg::LatW-1:0] report_lat_i,
  input  logic signed [gfmt_pkg::LonW-1:0] report_lon_i,
  input  logic                             location_updated_i,
  input  logic                             location_valid_i,
  input  logic                             hdop_valid_i,
  input  logic [gfmt_pkg::HdopW-1:0]       hdop_value_i,
  input  logic [gfmt_pkg::TimeW-1:0]       now_ms_i,
  input  logic                             out_valid_i,
  input  logic                             out_ready_i,
  input  logic signed [gfmt_pkg::LatW-1:0] out_lat_i,
  input  logic signed [gfmt_pkg::LonW-1:0] out_lon_i,
  input  logic                             fix_valid_i,
  input  logic                             fix_acquired_i,
  input  logic                             fix_lost_i,
  input  logic [gfmt_pkg::DistW-1:0]       distance_mm_i,
  input  logic                             moved_i,
  input  logic [gfmt_pkg::TimeW-1:0]       since_move_ms_i,
  input  logic                             cfg_we_i,
  input  gfmt_pkg::cfg_index_e             cfg_index_i,
  input  logic [gfmt_pkg::CfgDataW-1:0]    cfg_data_i,
  output int                               fail_count_o,
  output int                               pending_o
);
  import gfmt_pkg::*;

  // One predicted result beat.
  typedef struct {
    logic signed [LatW-1:0] lat;
    logic signed [LonW-1:0] lon;
    logic                   fix;
    logic                   acquired;
    logic                   lost;
    logic [DistW-1:0]       range_mm;
    logic                   moved;
    logic [TimeW-1:0]       since;
  } track_result_t;

  track_result_t expected_results[$];
  track_result_t oldest;
  int fail_count = 0;

  // Model state: location ring, held HDOP, fix history and reference.
  logic signed [31:0] lat_ring [3];
  logic signed [31:0] lon_ring [3];
  logic [1:0]         ring_slot;
  logic               ring_full;
  logic [HdopW-1:0]   hdop_held;
  logic               fix_prev;
  logic signed [31:0] anchor_lat;
  logic signed [31:0] anchor_lon;
  logic [TimeW-1:0]   anchor_ms;
  logic [DistW-1:0]   dist_held;
  logic [HdopW-1:0]   hdop_limit_q;
  logic [ThrW-1:0]    move_thr_q;

  assign fail_count_o = fail_count;
  assign pending_o    = expected_results.size();

  // The middle value of three; equal values give that value.
  function automatic logic signed [31:0] middle_of(input logic signed [31:0] a,
                                                   input logic signed [31:0] b,
                                                   input logic signed [31:0] c);
    if ((a <= b && b <= c) || (c <= b && b <= a)) return b;
    if ((b <= a && a <= c) || (c <= a && a <= b)) return a;
    return c;
  endfunction

  // Floor square root, built up one result bit at a time from the top.
  function automatic logic [31:0] floor_root(input logic [63:0] v);
    logic [31:0] root;
    logic [31:0] trial;
    root = '0;
    for (int i = 31; i >= 0; i--) begin
      trial = root | (32'd1 << i);
      if (64'(trial) * 64'(trial) <= v) root = trial;
    end
    return root;
  endfunction

  // Distance to the reference in millimetres: one step is 11.132 mm.
  function automatic logic [31:0] range_to_anchor(input logic signed [31:0] la,
                                                  input logic signed [31:0] lo);
    logic signed [32:0] d_lat;
    logic signed [32:0] d_lon;
    logic [64:0]        sq_sum;
    logic [63:0]        scaled;
    d_lat = la - anchor_lat;
    d_lon = lo - anchor_lon;
    if (d_lat < 0) d_lat = -d_lat;
    if (d_lon < 0) d_lon = -d_lon;
    sq_sum = 65'(d_lat[31:0]) * 65'(d_lat[31:0]) + 65'(d_lon[31:0]) * 65'(d_lon[31:0]);
    // A square sum that no longer fits 64 bits saturates.
    if (sq_sum[64]) return '1;
    scaled = 64'(floor_root(sq_sum[63:0])) * 64'd11132 / 64'd1000;
    return (scaled > 64'h0000_0000_FFFF_FFFF) ? '1 : scaled[31:0];
  endfunction

  task automatic clear_model();
    for (int i = 0; i < 3; i++) begin
      lat_ring[i] = '0;
      lon_ring[i] = '0;
    end
    ring_slot    = '0;
    ring_full    = 1'b0;
    hdop_held    = 14'd9990;
    fix_prev     = 1'b0;
    anchor_lat   = '0;
    anchor_lon   = '0;
    anchor_ms    = '0;
    dist_held    = '0;
    hdop_limit_q = 14'd300;
    move_thr_q   = 16'd1000;
    expected_results.delete();
  endtask

  // Works out the result of one accepted report and queues it.
  task automatic predict_report(input logic signed [LatW-1:0] r_lat,
                                input logic signed [LonW-1:0] r_lon,
                                input logic upd, input logic lval, input logic hval,
                                input logic [HdopW-1:0] hv, input logic [TimeW-1:0] now);
    logic signed [31:0] o_lat;
    logic signed [31:0] o_lon;
    logic [1:0]         slot;
    logic               fix_now;
    logic               move_now;
    track_result_t      res;
    o_lat    = r_lat;
    o_lon    = r_lon;
    move_now = 1'b0;
    // Only a fresh, valid location enters the ring.
    if (upd && lval) begin
      slot           = (ring_slot < 2'd3) ? ring_slot : 2'd0;
      lat_ring[slot] = o_lat;
      lon_ring[slot] = o_lon;
      ring_slot      = (slot == 2'd2) ? 2'd0 : slot + 2'd1;
      if (ring_slot == 2'd0) ring_full = 1'b1;
    end
    if (hval) hdop_held = hv;
    fix_now = lval && (hdop_held < hdop_limit_q);
    if (ring_full && lval) begin
      o_lat = middle_of(lat_ring[0], lat_ring[1], lat_ring[2]);
      o_lon = middle_of(lon_ring[0], lon_ring[1], lon_ring[2]);
    end
    // A zero in either reference coordinate means there is no reference yet.
    if (fix_now) begin
      if (anchor_lat != 0 && anchor_lon != 0) begin
        dist_held = range_to_anchor(o_lat, o_lon);
        move_now  = dist_held > 32'(move_thr_q);
      end else begin
        move_now = 1'b1;
      end
    end
    if (move_now) begin
      anchor_lat = o_lat;
      anchor_lon = o_lon;
      anchor_ms  = now;
    end
    res.lat      = o_lat[LatW-1:0];
    res.lon      = o_lon;
    res.fix      = fix_now;
    res.acquired = fix_now && !fix_prev;
    res.lost     = !fix_now && fix_prev;
    res.range_mm = dist_held;
    res.moved    = move_now;
    res.since    = (anchor_ms == '0) ? '0 : now - anchor_ms;
    fix_prev     = fix_now;
    expected_results.push_back(res);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  // Result beats are checked before the report beat of the same edge is
  // predicted, so a beat can never match a report accepted with it.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_model();
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_results.size() == 0) begin
          fail_count++;
          $display("%0t: result beat with no report waiting, expected none, got lat %0h",
                   $time, out_lat_i);
        end else begin
          oldest = expected_results.pop_front();
          check_field("out_lat", 32'(oldest.lat), 32'(out_lat_i));
          check_field("out_lon", oldest.lon, out_lon_i);
          check_field("fix_valid", 32'(oldest.fix), 32'(fix_valid_i));
          check_field("fix_acquired", 32'(oldest.acquired), 32'(fix_acquired_i));
          check_field("fix_lost", 32'(oldest.lost), 32'(fix_lost_i));
          check_field("distance_mm", oldest.range_mm, distance_mm_i);
          check_field("moved", 32'(oldest.moved), 32'(moved_i));
          check_field("since_move_ms", oldest.since, since_move_ms_i);
        end
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          CfgHdopLimit: hdop_limit_q = cfg_data_i[HdopW-1:0];
          CfgMoveThr:   move_thr_q   = cfg_data_i[ThrW-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i)
        predict_report(report_lat_i, report_lon_i, location_updated_i, location_valid_i,
                       hdop_valid_i, hdop_value_i, now_ms_i);
    end
  end

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench top for the position filter and motion tracker
// Drives a short directed sequence over the field extremes and special cases,
// then random receiver tracks under several register settings, with random
// idling on both channels, a long result hold-off and a full drain. The
// checker beside the block predicts and compares; this module gives the
// verdict.
// ----------------------------------------------------------------------------
module tb_top;
  import gfmt_pkg::*;

  localparam int ClkHalf       = 4;
  localparam int PhaseCount    = 6;
  localparam int PhaseReports  = 320;
  localparam int HoldCycles    = 400;
  localparam int DrainCycles   = 100;
  localparam int WatchdogLimit = 4000;

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   in_valid_i;
  logic                   in_ready_o;
  logic signed [LatW-1:0] report_lat_i;
  logic signed [LonW-1:0] report_lon_i;
  logic                   location_updated_i;
  logic                   location_valid_i;
  logic                   hdop_valid_i;
  logic [HdopW-1:0]       hdop_value_i;
  logic [TimeW-1:0]       now_ms_i;
  logic                   out_valid_o;
  logic                   out_ready_i;
  logic signed [LatW-1:0] out_lat_o;
  logic signed [LonW-1:0] out_lon_o;
  logic                   fix_valid_o;
  logic                   fix_acquired_o;
  logic                   fix_lost_o;
  logic [DistW-1:0]       distance_mm_o;
  logic                   moved_o;
  logic [TimeW-1:0]       since_move_ms_o;
  logic                   cfg_we_i;
  cfg_index_e             cfg_index_i;
  logic [CfgDataW-1:0]    cfg_data_i;

  int fail_count;
  int pending;

  // Shared controls for the two channel drivers.
  logic gaps_on     = 1'b1;
  logic rx_hold_req = 1'b0;

  // Random track state.
  longint           trk_lat;
  longint           trk_lon;
  int unsigned      jit;
  int               seq_left = 0;
  logic [TimeW-1:0] clock_ms = '0;
  int unsigned      cur_limit = 300;

  int unsigned lim_set [PhaseCount] = '{9999, 0, 16'hC12C, 5000, 1, 300};
  int unsigned thr_set [PhaseCount] = '{0, 65535, 200, 5, 1, 1000};

  always #(ClkHalf) clk_i = ~clk_i;

  gps_fix_median_motion_tracker uut (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_o,
    .report_lat_i, .report_lon_i, .location_updated_i, .location_valid_i,
    .hdop_valid_i, .hdop_value_i, .now_ms_i,
    .out_valid_o, .out_ready_i,
    .out_lat_o, .out_lon_o, .fix_valid_o, .fix_acquired_o, .fix_lost_o,
    .distance_mm_o, .moved_o, .since_move_ms_o,
    .cfg_we_i, .cfg_index_i, .cfg_data_i
  );

  gps_fix_median_motion_tracker_checker tracker_check (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_i(in_ready_o),
    .report_lat_i, .report_lon_i, .location_updated_i, .location_valid_i,
    .hdop_valid_i, .hdop_value_i, .now_ms_i,
    .out_valid_i(out_valid_o), .out_ready_i,
    .out_lat_i(out_lat_o), .out_lon_i(out_lon_o), .fix_valid_i(fix_valid_o),
    .fix_acquired_i(fix_acquired_o), .fix_lost_i(fix_lost_o),
    .distance_mm_i(distance_mm_o), .moved_i(moved_o), .since_move_ms_i(since_move_ms_o),
    .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // Offers one report beat and returns on the falling edge after acceptance.
  task automatic send_report(input logic signed [LatW-1:0] lat,
                             input logic signed [LonW-1:0] lon,
                             input logic upd, input logic lval, input logic hval,
                             input logic [HdopW-1:0] hv, input logic [TimeW-1:0] ms);
    while (gaps_on && $urandom_range(99) < 24) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    report_lat_i       = lat;
    report_lon_i       = lon;
    location_updated_i = upd;
    location_valid_i   = lval;
    hdop_valid_i       = hval;
    hdop_value_i       = hv;
    now_ms_i           = ms;
    in_valid_i         = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  // Stops offering and waits until every predicted result has arrived.
  task automatic wait_drain();
    in_valid_i = 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  task automatic write_register(input cfg_index_e idx, input logic [CfgDataW-1:0] data);
    cfg_we_i    = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  function automatic longint spread(input int unsigned span);
    return longint'($urandom_range(0, 2 * span)) - longint'(span);
  endfunction

  function automatic longint clamp(input longint v, input longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  // HDOP values clustered around the current limit, plus values above range.
  function automatic logic [HdopW-1:0] pick_hdop();
    int unsigned lim;
    lim = (cur_limit > 16383) ? 16383 : cur_limit;
    case ($urandom_range(9))
      0, 1, 2, 3, 4: return HdopW'($urandom_range(0, (lim == 0) ? 0 : lim - 1));
      5, 6:          return HdopW'($urandom_range(0, 9999));
      7:             return HdopW'($urandom_range(10000, 16383));
      8:             return HdopW'(lim);
      default:       return '0;
    endcase
  endfunction

  // Mostly well-formed tracks: jittered positions around a base, with
  // outliers, stale reports and some full-width noise.
  task automatic random_report();
    longint                 lat;
    longint                 lon;
    logic signed [LatW-1:0] r_lat;
    logic signed [LonW-1:0] r_lon;
    logic                   upd;
    logic                   lval;
    logic                   hval;
    logic [HdopW-1:0]       hv;
    int unsigned            roll;
    if (seq_left == 0) begin
      seq_left = $urandom_range(4, 40);
      case ($urandom_range(4))
        0:       jit = 0;
        1:       jit = 20;
        2:       jit = 300;
        3:       jit = 20000;
        default: jit = 500000000;
      endcase
      roll = $urandom_range(99);
      if (roll < 10) begin
        trk_lat = 0;
        trk_lon = longint'($urandom_range(0, 32'd3600000000)) - 1800000000;
        jit     = 0;
      end else if (roll < 15) begin
        trk_lon = 0;
        jit     = 0;
      end else if (roll < 50) begin
        trk_lat = longint'($urandom_range(0, 32'd1800000000)) - 900000000;
        trk_lon = longint'($urandom_range(0, 32'd3600000000)) - 1800000000;
      end else begin
        trk_lat = clamp(trk_lat + spread(20000), 900000000);
        trk_lon = clamp(trk_lon + spread(20000), 1800000000);
      end
    end
    seq_left--;
    clock_ms = clock_ms + $urandom_range(0, 1500);
    if ($urandom_range(99) == 0)
      clock_ms = $urandom_range(1) ? '0 : 32'hFFFF_FFFF - $urandom_range(3000);
    roll = $urandom_range(99);
    hval = $urandom_range(99) < 60;
    hv   = pick_hdop();
    lat  = trk_lat + spread(jit);
    lon  = trk_lon + spread(jit);
    if ($urandom_range(99) < 8) begin
      lat = lat + spread(5000000);
      lon = lon + spread(5000000);
    end
    r_lat = LatW'(clamp(lat, 900000000));
    r_lon = LonW'(clamp(lon, 1800000000));
    if (roll < 80) begin
      upd  = 1'b1;
      lval = $urandom_range(19) != 0;
    end else if (roll < 90) begin
      upd  = 1'b0;
      lval = 1'($urandom_range(1));
    end else begin
      r_lat = LatW'($urandom);
      r_lon = LonW'($urandom);
      upd   = 1'($urandom_range(1));
      lval  = 1'($urandom_range(1));
      hval  = 1'($urandom_range(1));
      hv    = HdopW'($urandom);
    end
    send_report(r_lat, r_lon, upd, lval, hval, hv, clock_ms);
  endtask

  // Result side: random ready, with one long hold-off on request.
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        out_ready_i = 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
      end
      out_ready_i = gaps_on ? ($urandom_range(99) >= 24) : 1'b1;
    end
  end

  // Ends the run when no beat moves on either channel for too long.
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WatchdogLimit) begin
      @(posedge clk_i);
      if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
        quiet = 0;
      else
        quiet++;
    end
    $display("[gps_fix_median_motion_tracker] ERROR");
    $finish;
  end

  initial begin
    rst_ni             = 1'b0;
    in_valid_i         = 1'b0;
    report_lat_i       = '0;
    report_lon_i       = '0;
    location_updated_i = 1'b0;
    location_valid_i   = 1'b0;
    hdop_valid_i       = 1'b0;
    hdop_value_i       = '0;
    now_ms_i           = '0;
    cfg_we_i           = 1'b0;
    cfg_index_i        = CfgHdopLimit;
    cfg_data_i         = '0;
    trk_lat            = 0;
    trk_lon            = 0;
    jit                = 0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part under the reset settings.
    // Stale, invalid report at the range extremes passes through raw.
    send_report(31'sd900000000, 32'sd1800000000, 1'b0, 1'b0, 1'b0, 14'd0, 32'd0);
    // Valid locations at the full-width minimum; held HDOP still blocks the fix,
    // then an above-range HDOP is held as given.
    send_report(31'sh4000_0000, 32'sh8000_0000, 1'b1, 1'b1, 1'b0, 14'd16383, 32'd1);
    send_report(31'sh4000_0000, 32'sh8000_0000, 1'b1, 1'b1, 1'b1, 14'd16383, 32'd2);
    // Fix acquired with no reference, at time zero: since stays zero.
    send_report(31'sh4000_0000, 32'sh8000_0000, 1'b1, 1'b1, 1'b1, 14'd299, 32'd0);
    // Opposite corner: the square sum overflows and the distance saturates.
    send_report(31'sh3FFF_FFFF, 32'sh7FFF_FFFF, 1'b1, 1'b1, 1'b0, 14'd0, 32'd7);
    send_report(31'sh3FFF_FFFF, 32'sh7FFF_FFFF, 1'b1, 1'b1, 1'b0, 14'd0, 32'd9);
    // Updated but invalid location is not stored; HDOP at the limit loses the fix.
    send_report(-31'sd900000000, -32'sd1800000000, 1'b1, 1'b0, 1'b1, 14'd300, 32'd20);
    // Valid but not updated: median output, no fix with HDOP at the limit.
    send_report(31'sd5, 32'sd5, 1'b0, 1'b1, 1'b0, 14'd0, 32'd30);
    // Equal positions give ties in the median.
    send_report(31'sd123456, -32'sd654321, 1'b1, 1'b1, 1'b1, 14'd0, 32'd40);
    send_report(31'sd123456, -32'sd654321, 1'b1, 1'b1, 1'b0, 14'd0, 32'd50);
    send_report(31'sd123456, -32'sd654321, 1'b1, 1'b1, 1'b0, 14'd0, 32'd60);
    // Small step below the threshold, then a step just above it.
    send_report(31'sd123506, -32'sd654321, 1'b1, 1'b1, 1'b0, 14'd0, 32'd70);
    send_report(31'sd123506, -32'sd654321, 1'b1, 1'b1, 1'b0, 14'd0, 32'd80);
    send_report(31'sd123546, -32'sd654321, 1'b1, 1'b1, 1'b0, 14'd0, 32'd90);
    send_report(31'sd123546, -32'sd654321, 1'b1, 1'b1, 1'b0, 14'd0, 32'd100);
    // A reference with zero latitude counts as no reference.
    send_report(31'sd0, 32'sd777, 1'b1, 1'b1, 1'b0, 14'd0, 32'd110);
    send_report(31'sd0, 32'sd777, 1'b1, 1'b1, 1'b0, 14'd0, 32'd120);
    send_report(31'sd0, 32'sd777, 1'b1, 1'b1, 1'b0, 14'd0, 32'd130);
    // Millisecond time wraps between a move and the next report.
    send_report(31'sd0, 32'sd777, 1'b1, 1'b1, 1'b0, 14'd0, 32'hFFFF_FFFF);
    send_report(31'sd1000, 32'sd777, 1'b1, 1'b0, 1'b0, 14'd0, 32'd10);
    send_report(31'sd1000, 32'sd777, 1'b1, 1'b1, 1'b1, 14'd9999, 32'd15);
    wait_drain();

    // Random tracks under several register settings.
    for (int p = 0; p < PhaseCount; p++) begin
      wait_drain();
      write_register(CfgHdopLimit, CfgDataW'(lim_set[p]));
      write_register(CfgMoveThr, CfgDataW'(thr_set[p]));
      cur_limit = lim_set[p] & 32'h3FFF;
      gaps_on   = (p != 2);
      for (int n = 0; n < PhaseReports; n++) begin
        if (p == 3 && n == 40) rx_hold_req = 1'b1;
        if (p == 4 && n == 100) wait_drain();
        random_report();
      end
    end

    wait_drain();
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0)
      $display("[gps_fix_median_motion_tracker] OK");
    else
      $display("[gps_fix_median_motion_tracker] ERROR");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+sv
sv/gfmt_pkg.sv
sv/gfmt_front.sv
sv/gfmt_queue.sv
sv/gfmt_isqrt.sv
sv/gfmt_back.sv
sv/gps_fix_median_motion_tracker.sv
sv/gfmt_checker.sv
sim/gps_fix_median_motion_tracker_checker.sv
sim/tb_top.sv
